### design/spike_filtered_mean_heading_defines.svh
// Assertion macros used by the checker file of this block.
`ifndef SPIKE_FILTERED_MEAN_HEADING_DEFINES_SVH
`define SPIKE_FILTERED_MEAN_HEADING_DEFINES_SVH

// Check that is switched off while reset is held.
`define SFMH_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sfmh check failed");

// Check that also looks at the cycles under reset.
`define SFMH_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sfmh reset check failed");

`endif

### design/sfmh_pkg.sv
package sfmh_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int THR_W        = 16;
  localparam int HEAD_W       = 15;
  localparam int WIN_LOG2     = 3;
  localparam int WINDOW_LEN   = 1 << WIN_LOG2;
  localparam int CNT_W        = WIN_LOG2;
  localparam int SUM_W        = SAMPLE_W + WIN_LOG2;
  localparam int THRESH_RESET = 200;

  localparam int ITERS        = 16;
  localparam int IT_W         = $clog2(ITERS);
  localparam int XY_W         = 32;
  localparam int Z_W          = 26;
  localparam int PRE_SHIFT    = 14;
  localparam int HALF_TURN_Z  = 180 * 65536;
  localparam int ROUND_BIAS   = 512;
  localparam int HEAD_SHIFT   = 10;
  localparam int HQ_W         = Z_W - HEAD_SHIFT;
  localparam int HEADING_MAX  = 11520;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_SETUP,
    ST_ROT,
    ST_EMIT
  } sfmh_state_t;

  // Window hand-off from the filter to the heading unit.
  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
  } sfmh_win_t;

  // atan(2^-i) in degrees, scaled by 65536 and rounded.
  function automatic logic signed [Z_W-1:0] atan_lut(input logic [IT_W-1:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      4'd0:    v = Z_W'(2949120);
      4'd1:    v = Z_W'(1740967);
      4'd2:    v = Z_W'(919879);
      4'd3:    v = Z_W'(466945);
      4'd4:    v = Z_W'(234379);
      4'd5:    v = Z_W'(117304);
      4'd6:    v = Z_W'(58666);
      4'd7:    v = Z_W'(29335);
      4'd8:    v = Z_W'(14668);
      4'd9:    v = Z_W'(7334);
      4'd10:   v = Z_W'(3667);
      4'd11:   v = Z_W'(1833);
      4'd12:   v = Z_W'(917);
      4'd13:   v = Z_W'(458);
      4'd14:   v = Z_W'(229);
      4'd15:   v = Z_W'(115);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### design/sfmh_if.sv
interface sfmh_in_if import sfmh_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_x;
  logic signed [SAMPLE_W-1:0] sample_y;

  modport source (output valid, sample_x, sample_y, input ready);
  modport sink   (input valid, sample_x, sample_y, output ready);
endinterface

interface sfmh_out_if import sfmh_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] mean_x;
  logic signed [SAMPLE_W-1:0] mean_y;
  logic signed [HEAD_W-1:0]   heading;

  modport source (output valid, mean_x, mean_y, heading, input ready);
  modport sink   (input valid, mean_x, mean_y, heading, output ready);
endinterface

### design/sfmh_filter.sv
module sfmh_filter import sfmh_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [THR_W-1:0]           cfg_wdata,
  input  logic                       in_fire,
  input  logic signed [SAMPLE_W-1:0] sample_x,
  input  logic signed [SAMPLE_W-1:0] sample_y,
  output sfmh_win_t                  win
);

  logic [THR_W-1:0]           thresh_r, thresh_nxt;
  logic signed [SAMPLE_W-1:0] kept_x_r, kept_x_nxt;
  logic signed [SAMPLE_W-1:0] kept_y_r, kept_y_nxt;
  logic signed [SUM_W-1:0]    sum_x_r, sum_x_nxt;
  logic signed [SUM_W-1:0]    sum_y_r, sum_y_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic                       first;
  logic                       last;

  // A sample that jumps further than the threshold from the last kept value
  // is replaced by that kept value. The first sample of a window always passes.
  function automatic logic signed [SAMPLE_W-1:0] pick(
    input logic signed [SAMPLE_W-1:0] s,
    input logic signed [SAMPLE_W-1:0] k,
    input logic [THR_W-1:0]           thr,
    input logic                       is_first
  );
    logic signed [SAMPLE_W:0] d;
    logic [SAMPLE_W:0]        mag;
    d   = {s[SAMPLE_W-1], s} - {k[SAMPLE_W-1], k};
    mag = d[SAMPLE_W] ? -d : d;
    if (!is_first && (mag > {1'b0, thr})) begin
      return k;
    end
    return s;
  endfunction

  assign first = (count_r == '0);
  assign last  = (count_r == CNT_W'(WINDOW_LEN - 1));

  always_comb begin
    thresh_nxt = cfg_we ? cfg_wdata : thresh_r;
    kept_x_nxt = kept_x_r;
    kept_y_nxt = kept_y_r;
    sum_x_nxt  = sum_x_r;
    sum_y_nxt  = sum_y_r;
    count_nxt  = count_r;
    if (in_fire) begin
      kept_x_nxt = pick(sample_x, kept_x_r, thresh_r, first);
      kept_y_nxt = pick(sample_y, kept_y_r, thresh_r, first);
      sum_x_nxt  = first ? SUM_W'(kept_x_nxt) : sum_x_r + SUM_W'(kept_x_nxt);
      sum_y_nxt  = first ? SUM_W'(kept_y_nxt) : sum_y_r + SUM_W'(kept_y_nxt);
      count_nxt  = last ? '0 : count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THR_W'(THRESH_RESET);
      kept_x_r <= '0;
      kept_y_r <= '0;
      sum_x_r  <= '0;
      sum_y_r  <= '0;
      count_r  <= '0;
    end else begin
      thresh_r <= thresh_nxt;
      kept_x_r <= kept_x_nxt;
      kept_y_r <= kept_y_nxt;
      sum_x_r  <= sum_x_nxt;
      sum_y_r  <= sum_y_nxt;
      count_r  <= count_nxt;
    end
  end

  // The sums are registered at the same edge as the last transfer, so the
  // heading unit reads them in the following cycle.
  assign win.start = in_fire && last;
  assign win.sum_x = sum_x_r;
  assign win.sum_y = sum_y_r;

endmodule

### design/sfmh_heading.sv
module sfmh_heading import sfmh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  sfmh_win_t         win,
  output logic              busy,
  sfmh_out_if.source        out_ch
);

  sfmh_state_t                state_r, state_nxt;
  logic [IT_W-1:0]            it_r, it_nxt;
  logic signed [SAMPLE_W-1:0] mx_r, mx_nxt;
  logic signed [SAMPLE_W-1:0] my_r, my_nxt;
  logic signed [XY_W-1:0]     x_r, x_nxt;
  logic signed [XY_W-1:0]     y_r, y_nxt;
  logic signed [Z_W-1:0]      z_r, z_nxt;
  logic                       zero_r, zero_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_mx_r, out_mx_nxt;
  logic signed [SAMPLE_W-1:0] out_my_r, out_my_nxt;
  logic signed [HEAD_W-1:0]   out_h_r, out_h_nxt;

  // Divide by the window length, truncating toward zero.
  function automatic logic signed [SAMPLE_W-1:0] mean_of(
    input logic signed [SUM_W-1:0] s
  );
    logic [SUM_W-1:0] b;
    b = s + (s[SUM_W-1] ? SUM_W'(WINDOW_LEN - 1) : SUM_W'(0));
    return b[SUM_W-1:WIN_LOG2];
  endfunction

  always_comb begin
    logic signed [XY_W-1:0] ex;
    logic signed [XY_W-1:0] ey;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [Z_W-1:0]  zr;
    logic signed [HQ_W-1:0] hq;
    logic signed [HQ_W-1:0] hs;

    state_nxt     = state_r;
    it_nxt        = it_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    z_nxt         = z_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r;
    out_mx_nxt    = out_mx_r;
    out_my_nxt    = out_my_r;
    out_h_nxt     = out_h_r;

    ex = XY_W'(my_r);
    ey = XY_W'(mx_r);
    xs = x_r >>> it_r;
    ys = y_r >>> it_r;
    zr = z_r + Z_W'(ROUND_BIAS);
    hq = zr[Z_W-1:HEAD_SHIFT];
    if (hq > HQ_W'(HEADING_MAX)) begin
      hs = HQ_W'(HEADING_MAX);
    end else if (hq < -HQ_W'(HEADING_MAX)) begin
      hs = -HQ_W'(HEADING_MAX);
    end else begin
      hs = hq;
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (win.start) begin
          state_nxt = ST_MEAN;
        end
      end
      ST_MEAN: begin
        mx_nxt    = mean_of(win.sum_x);
        my_nxt    = mean_of(win.sum_y);
        state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        // The CORDIC x axis is mean_y and its y axis is mean_x. A point in
        // the left half plane is mirrored and starts from a half turn.
        zero_nxt = (mx_r == '0) && (my_r == '0);
        if (my_r[SAMPLE_W-1]) begin
          z_nxt = mx_r[SAMPLE_W-1] ? -Z_W'(HALF_TURN_Z) : Z_W'(HALF_TURN_Z);
          x_nxt = (-ex) <<< PRE_SHIFT;
          y_nxt = (-ey) <<< PRE_SHIFT;
        end else begin
          z_nxt = '0;
          x_nxt = ex <<< PRE_SHIFT;
          y_nxt = ey <<< PRE_SHIFT;
        end
        it_nxt    = '0;
        state_nxt = ST_ROT;
      end
      ST_ROT: begin
        if (!y_r[XY_W-1]) begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + atan_lut(it_r);
        end else begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - atan_lut(it_r);
        end
        it_nxt = it_r + IT_W'(1);
        if (it_r == IT_W'(ITERS - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_mx_nxt    = mx_r;
          out_my_nxt    = my_r;
          out_h_nxt     = zero_r ? '0 : hs[HEAD_W-1:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    it_r     <= it_nxt;
    mx_r     <= mx_nxt;
    my_r     <= my_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    z_r      <= z_nxt;
    zero_r   <= zero_nxt;
    out_mx_r <= out_mx_nxt;
    out_my_r <= out_my_nxt;
    out_h_r  <= out_h_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.mean_x  = out_mx_r;
  assign out_ch.mean_y  = out_my_r;
  assign out_ch.heading = out_h_r;

endmodule

### design/spike_filtered_mean_heading.sv
// Spike-filtered windowed mean and compass heading. Each transfer on in_ch
// carries one signed X/Y sample pair; eight pairs make a window. Within a
// window, a sample that jumps from the last kept value of its axis by more
// than the threshold written on cfg_wdata (reset value 200) is replaced by
// that kept value; the first sample of a window is always kept. At the end
// of each window one result appears on out_ch: both means (truncated toward
// zero) and heading = atan2(mean_x, mean_y) in 1/64 degree, -11520..11520,
// 0 when both means are zero. Samples that do not close a window never hold
// in_ch.ready low. The closing sample holds in_ch.ready low through the
// division, setup, sixteen passes through the single shift-and-add CORDIC
// unit and the load of the output register, plus any wait on out_ch.ready
// for the previous result. A waiting result does not block new samples.
module spike_filtered_mean_heading import sfmh_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_wdata,
  sfmh_in_if.sink          in_ch,
  sfmh_out_if.source       out_ch
);

  sfmh_win_t win;
  logic      busy;
  logic      in_fire;

  assign in_ch.ready = !busy;
  assign in_fire     = in_ch.valid && in_ch.ready;

  sfmh_filter u_filter (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .sample_x  (in_ch.sample_x),
    .sample_y  (in_ch.sample_y),
    .win       (win)
  );

  sfmh_heading u_heading (
    .clk    (clk),
    .rst_n  (rst_n),
    .win    (win),
    .busy   (busy),
    .out_ch (out_ch)
  );

endmodule

### design/sfmh_checker.sv
`include "spike_filtered_mean_heading_defines.svh"

module sfmh_checker import sfmh_pkg::*; (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] mean_x,
  input logic signed [SAMPLE_W-1:0] mean_y,
  input logic signed [HEAD_W-1:0]   heading
);

  // A result that is not taken must wait unchanged.
  `SFMH_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(mean_x) && $stable(mean_y) && $stable(heading))

  // The block only stops taking samples after it has taken one.
  `SFMH_ASSERT(a_ready_drop, $fell(in_ready) |-> $past(in_valid && in_ready))

  `SFMH_ASSERT(a_head_range, out_valid |-> heading <= HEADING_MAX && heading >= -HEADING_MAX)

  // Both means zero gives a zero heading.
  `SFMH_ASSERT(a_zero_head, out_valid && mean_x == 0 && mean_y == 0 |-> heading == 0)

  `SFMH_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid)

endmodule

bind spike_filtered_mean_heading sfmh_checker u_sfmh_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .mean_x    (out_ch.mean_x),
  .mean_y    (out_ch.mean_y),
  .heading   (out_ch.heading)
);
